// ===== rtl/bive_pkg.sv =====
// Shared types, constants and a helper function of the bucketed interval value encoder.
package bive_pkg;

  // Fixed field widths
  localparam int unsigned ValueW    = 20;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CodeW     = 30;
  localparam int unsigned LenW      = 5;
  localparam int unsigned ExtraW    = 15;
  localparam int unsigned NibW      = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned FiwW      = 4;
  localparam int unsigned MinW      = 16;
  localparam int unsigned WidthsW   = 64;
  localparam int unsigned OutDataW  = 40;

  // Configuration port
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned ApbAddrW  = 5;

  // Defaults for the top level parameters
  localparam int unsigned BucketLimitDef = 16;
  localparam int unsigned MaxExtraDef    = 15;

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;

  // Register indexes
  localparam logic [1:0] RegMinValue   = 2'd0;
  localparam logic [1:0] RegFlatWidth  = 2'd1;
  localparam logic [1:0] RegBucketCnt  = 2'd2;
  localparam logic [1:0] RegWidths     = 2'd3;

  // Reset values
  localparam logic [MinW-1:0]    RstMinValue  = 16'd1;
  localparam logic [FiwW-1:0]    RstFlatWidth = 4'd4;
  localparam logic [CntW-1:0]    RstBucketCnt = 5'd16;
  localparam logic [WidthsW-1:0] RstWidths    = 64'hFEDC_BA98_7654_3210;

  typedef struct packed {
    logic [MinW-1:0]    min_value;
    logic [FiwW-1:0]    flat_index_width;
    logic [CntW-1:0]    bucket_count;
    logic [WidthsW-1:0] bucket_widths;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   idx;
    logic [ExtraW-1:0] extra;
  } item_t;

  // Extra-bit width of one bucket, clamped to max_w
  function automatic logic [NibW-1:0] bucket_width(input logic [WidthsW-1:0] widths,
                                                   input logic [IdxW-1:0]    b,
                                                   input logic [NibW-1:0]    max_w);
    logic [NibW-1:0] w;
    w = widths[{b, 2'b00} +: NibW];
    if (w > max_w) begin
      w = max_w;
    end
    return w;
  endfunction

endpackage

// ===== rtl/bive_regs.sv =====
// Configuration registers behind the APB-style port.
module bive_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [bive_pkg::ApbAddrW-1:0] paddr_i,
  input  logic [bive_pkg::ApbDataW-1:0] pwdata_i,
  output logic [bive_pkg::ApbDataW-1:0] prdata_o,
  output logic                          pready_o,
  output bive_pkg::cfg_t                cfg_o
);
  import bive_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready_o = 1'b1;
  assign reg_sel  = paddr_i[4:3];
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegMinValue:  cfg_d.min_value        = pwdata_i[MinW-1:0];
        RegFlatWidth: cfg_d.flat_index_width = pwdata_i[FiwW-1:0];
        RegBucketCnt: cfg_d.bucket_count     = pwdata_i[CntW-1:0];
        RegWidths:    cfg_d.bucket_widths    = pwdata_i[WidthsW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_value        <= RstMinValue;
      cfg_q.flat_index_width <= RstFlatWidth;
      cfg_q.bucket_count     <= RstBucketCnt;
      cfg_q.bucket_widths    <= RstWidths;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    prdata_o = '0;
    unique case (reg_sel)
      RegMinValue:  prdata_o = ApbDataW'(cfg_q.min_value);
      RegFlatWidth: prdata_o = ApbDataW'(cfg_q.flat_index_width);
      RegBucketCnt: prdata_o = ApbDataW'(cfg_q.bucket_count);
      RegWidths:    prdata_o = ApbDataW'(cfg_q.bucket_widths);
      default:      prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bive_front.sv =====
// Front end: accepts values, keeps the bucket boundary table, finds the bucket.
module bive_front #(
  parameter int unsigned BUCKET_LIMIT    = bive_pkg::BucketLimitDef,
  parameter int unsigned MAX_EXTRA_WIDTH = bive_pkg::MaxExtraDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bive_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bive_pkg::ValueW-1:0]  in_value_i,
  output logic                         push_o,
  input  logic                         q_full_i,
  output bive_pkg::item_t              item_o
);
  import bive_pkg::*;

  // Boundary sums must hold min_value plus every bucket size
  localparam int unsigned SumW   = $clog2((1 << MinW) + BUCKET_LIMIT * (1 << MAX_EXTRA_WIDTH) + 1);
  localparam int unsigned CmpW   = (SumW > ValueW) ? SumW : ValueW;
  localparam int unsigned Levels = $clog2(BUCKET_LIMIT);
  localparam logic [NibW-1:0] MaxW = NibW'(MAX_EXTRA_WIDTH);

  logic [SumW-1:0] size_w [BUCKET_LIMIT];
  logic [SumW-1:0] lvl    [Levels+1][BUCKET_LIMIT];
  logic [SumW-1:0] start_d [BUCKET_LIMIT];
  logic [SumW-1:0] start_q [BUCKET_LIMIT];
  logic [SumW-1:0] end_d   [BUCKET_LIMIT];
  logic [SumW-1:0] end_q   [BUCKET_LIMIT];

  // Bucket sizes
  for (genvar b = 0; b < BUCKET_LIMIT; b++) begin : g_size
    assign size_w[b]  = SumW'(1) << bucket_width(cfg_i.bucket_widths, IdxW'(b), MaxW);
    assign lvl[0][b]  = size_w[b];
  end

  // Parallel prefix sum of the sizes, log2 levels deep
  for (genvar k = 0; k < Levels; k++) begin : g_lvl
    for (genvar b = 0; b < BUCKET_LIMIT; b++) begin : g_node
      if (b >= (1 << k)) begin : g_add
        assign lvl[k+1][b] = lvl[k][b] + lvl[k][b-(1<<k)];
      end else begin : g_pass
        assign lvl[k+1][b] = lvl[k][b];
      end
    end
  end

  // Bucket bounds: start inclusive, end exclusive
  for (genvar b = 0; b < BUCKET_LIMIT; b++) begin : g_bound
    assign end_d[b] = SumW'(cfg_i.min_value) + lvl[Levels][b];
    if (b == 0) begin : g_first
      assign start_d[b] = SumW'(cfg_i.min_value);
    end else begin : g_next
      assign start_d[b] = end_d[b-1];
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  // Stage control: a holds the value, b lines it up with the bound table, c is classified
  logic                a_v_q, b_v_q, c_v_q;
  logic                a_en, b_en, c_en;
  logic [ValueW-1:0]   a_val_q, b_val_q;
  item_t               c_item_q, c_item_d;

  assign c_en       = !c_v_q || !q_full_i;
  assign b_en       = !b_v_q || c_en;
  assign a_en       = !a_v_q || b_en;
  assign in_ready_o = a_en;
  assign push_o     = c_v_q && !q_full_i;
  assign item_o     = c_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= in_valid_i;
      if (b_en) b_v_q <= a_v_q;
      if (c_en) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) a_val_q  <= in_value_i;
    if (b_en) b_val_q  <= a_val_q;
    if (c_en) c_item_q <= c_item_d;
  end

  // Bucket search: all compares in parallel, lowest hit wins
  logic [CntW-1:0] count_eff;
  logic [CmpW-1:0] v_ext;

  assign count_eff = (cfg_i.bucket_count > CntW'(BUCKET_LIMIT)) ? CntW'(BUCKET_LIMIT)
                                                                : cfg_i.bucket_count;
  assign v_ext     = CmpW'(b_val_q);

  always_comb begin
    logic [CmpW-1:0] diff;
    c_item_d = '0;
    for (int b = BUCKET_LIMIT - 1; b >= 0; b--) begin
      diff = v_ext - CmpW'(start_q[b]);
      if ((CntW'(b) < count_eff) && (v_ext >= CmpW'(start_q[b])) &&
          (v_ext < CmpW'(end_q[b]))) begin
        c_item_d.found = 1'b1;
        c_item_d.idx   = IdxW'(b);
        c_item_d.extra = diff[ExtraW-1:0];
      end
    end
  end

endmodule

// ===== rtl/bive_fifo.sv =====
// Short queue of classified items between front and back.
module bive_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bive_pkg::item_t data_i,
  input  logic            pop_i,
  output bive_pkg::item_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import bive_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntBits = $clog2(QDepth + 1);

  item_t              mem_q [QDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ===== rtl/bive_back.sv =====
// Back end: builds the codeword and length, holds the result in the output register.
module bive_back #(
  parameter int unsigned MAX_EXTRA_WIDTH = bive_pkg::MaxExtraDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bive_pkg::cfg_t                cfg_i,
  input  bive_pkg::item_t               item_i,
  input  logic                          q_empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bive_pkg::OutDataW-1:0] out_data_o
);
  import bive_pkg::*;

  localparam logic [NibW-1:0] MaxW = NibW'(MAX_EXTRA_WIDTH);

  logic                out_v_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  assign pop_o       = !q_empty_i && (!out_v_q || out_ready_i);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

  // Codeword assembly
  always_comb begin
    logic [NibW-1:0]  w;
    logic [IdxW:0]    n;
    logic [2:0]       k;
    logic [FiwW-1:0]  plen;
    logic [IdxW:0]    prefix;
    logic [15:0]      fmask;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;

    w     = bucket_width(cfg_i.bucket_widths, item_i.idx, MaxW);
    n     = {1'b0, item_i.idx} + 1'b1;
    fmask = (16'd1 << cfg_i.flat_index_width) - 16'd1;

    priority if (n[4]) k = 3'd4;
    else if (n[3])     k = 3'd3;
    else if (n[2])     k = 3'd2;
    else if (n[1])     k = 3'd1;
    else               k = 3'd0;

    if (cfg_i.flat_index_width != '0) begin
      plen   = cfg_i.flat_index_width;
      prefix = {1'b0, item_i.idx & fmask[IdxW-1:0]};
    end else begin
      plen   = {k, 1'b1};
      prefix = n;
    end

    code = (CodeW'(prefix) << w) | CodeW'(item_i.extra);
    len  = LenW'(plen) + LenW'(w);

    if (item_i.found) begin
      out_data_d = {len, code, item_i.idx, 1'b1};
    end else begin
      out_data_d = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_data_q <= out_data_d;
  end

endmodule

// ===== rtl/bucketed_interval_value_encoder.sv =====
// Top level of the bucketed interval value encoder.
//
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------------------
//  s_axis   | in        | one value to code per transaction
//  m_axis   | out       | in_range, bucket_index, code_bits, code_length per value
//  apb      | in/out    | min_value, flat_index_width, bucket_count, bucket_widths
//
// One value per cycle sustained while m_axis is ready; a value accepted on s_axis loads front
// stage a at that edge, then moves through b, c, the queue and the output register to m_axis valid.
// The bucket bound table is a registered parallel prefix sum over the bucket sizes.
// Reset clears all valid state and loads the register defaults; no clearing pass.
// A stall on m_axis fills the two-entry queue before s_axis tready drops.
module bucketed_interval_value_encoder #(
  parameter int unsigned BUCKET_LIMIT    = bive_pkg::BucketLimitDef,
  parameter int unsigned MAX_EXTRA_WIDTH = bive_pkg::MaxExtraDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [19:0] value_in, [23:20] zero
  input  logic [bive_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] in_range, [4:1] bucket_index, [34:5] code_bits, [39:35] code_length
  output logic [bive_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [bive_pkg::ApbAddrW-1:0] paddr_i,
  input  logic [bive_pkg::ApbDataW-1:0] pwdata_i,
  output logic [bive_pkg::ApbDataW-1:0] prdata_o,
  output logic                          pready_o
);
  import bive_pkg::*;

  cfg_t  cfg;
  item_t front_item, q_item;
  logic  push, pop, q_full, q_empty;

  bive_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  bive_front #(
    .BUCKET_LIMIT    (BUCKET_LIMIT),
    .MAX_EXTRA_WIDTH (MAX_EXTRA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_value_i (s_axis_tdata_i[ValueW-1:0]),
    .push_o     (push),
    .q_full_i   (q_full),
    .item_o     (front_item)
  );

  bive_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (pop),
    .data_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bive_back #(
    .MAX_EXTRA_WIDTH (MAX_EXTRA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (q_item),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
